// ----- rtl/ibpm_pkg.sv -----
// Package for the IQ block power meter: widths, controller states, command/status structs.
// No dependencies.
`timescale 1ns / 1ps
package ibpm_pkg;
  localparam int SampleW = 16;
  localparam int PowW    = 32;
  localparam int SumW    = 44;
  localparam int CntW    = 13;
  localparam int MaxBlock = 4096;
  localparam int DivW    = 64;

  typedef enum logic [2:0] {
    ST_ACC, ST_ROOT, ST_DIV1, ST_DIV2, ST_OUT
  } ibpm_state_t;

  typedef enum logic [1:0] {
    U_IDLE, U_DIV, U_SQRT
  } ibpm_unit_t;

  typedef enum logic [1:0] {
    JOB_MEAN, JOB_PEAK, JOB_INR, JOB_RDE
  } ibpm_job_t;

  typedef struct packed {
    logic acc;
    logic start_mean;
    logic start_inr;
    logic start_rde;
    logic load_out;
  } ibpm_cmd_t;

  typedef struct packed {
    logic closes;
    logic unit_done;
  } ibpm_sts_t;
endpackage

// ----- rtl/iq_block_power_meter_unit.sv -----
// IQ block power meter top level: threshold register, controller and datapath.
// Depends on ibpm_pkg, ibpm_ctrl, ibpm_datapath.
//
// channel  direction  handshake              payload
// in_      input      in_valid/in_ready      sample_i, sample_q, last_sample
// out_     output     out_valid/out_ready    metrics, rms, peak, block length
// cfg_     input      cfg_we                 rms_threshold
//
// One cycle per sample inside a block. A closing sample starts a block-end pass:
// a 64-step serial divider and two 16-step square roots share one unit.
// Reset clears accumulators, output valid and sets threshold to 328.
// Input stalls during the block-end pass, and longer while the previous result waits.
`timescale 1ns / 1ps
module iq_block_power_meter_unit import ibpm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [SampleW-1:0] in_sample_i,
  input  logic signed [SampleW-1:0] in_sample_q,
  input  logic                      in_last_sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_signal_present,
  output logic [15:0]               out_rms_level,
  output logic [31:0]               out_peak_power,
  output logic [22:0]               out_rc_metric,
  output logic [21:0]               out_lf_metric,
  output logic [14:0]               out_inr_metric,
  output logic [20:0]               out_rde_metric,
  output logic [12:0]               out_block_length,
  input  logic                      cfg_we,
  input  logic [15:0]               cfg_wdata
);
  logic [15:0] thr_r;
  ibpm_cmd_t cmd;
  ibpm_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= 16'd328;
    else if (cfg_we) thr_r <= cfg_wdata;
  end

  ibpm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  ibpm_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .in_sample_i, .in_sample_q, .in_last_sample,
    .thr(thr_r), .out_ready, .out_valid, .out_signal_present, .out_rms_level,
    .out_peak_power, .out_rc_metric, .out_lf_metric, .out_inr_metric,
    .out_rde_metric, .out_block_length
  );
endmodule

// ----- rtl/ibpm_ctrl.sv -----
// Controller state machine for the IQ block power meter.
// Depends on ibpm_pkg.
`timescale 1ns / 1ps
module ibpm_ctrl import ibpm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_valid,
  input  logic      out_ready,
  input  ibpm_sts_t sts,
  output ibpm_cmd_t cmd
);
  ibpm_state_t state_r, state_nxt;
  logic wait_r, wait_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_ACC;
      wait_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wait_r  <= wait_nxt;
    end
  end

  // wait_r: a unit command was issued, waiting for done
  always_comb begin
    state_nxt = state_r;
    wait_nxt  = wait_r;
    unique case (state_r)
      ST_ACC: if (in_valid && in_ready && sts.closes) begin
        state_nxt = ST_ROOT;
        wait_nxt  = 1'b0;
      end
      ST_ROOT, ST_DIV1, ST_DIV2: begin
        if (!wait_r) wait_nxt = 1'b1;
        else if (sts.unit_done) begin
          wait_nxt = 1'b0;
          state_nxt = (state_r == ST_ROOT) ? ST_DIV1 :
                      (state_r == ST_DIV1) ? ST_DIV2 : ST_OUT;
        end
      end
      ST_OUT: if (!out_valid || out_ready) state_nxt = ST_ACC;
      default: state_nxt = ST_ACC;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_ACC: begin
        in_ready = 1'b1;
        cmd.acc  = in_valid;
      end
      ST_ROOT: cmd.start_mean = !wait_r;
      ST_DIV1: cmd.start_inr  = !wait_r;
      ST_DIV2: cmd.start_rde  = !wait_r;
      ST_OUT:  cmd.load_out   = !out_valid || out_ready;
      default: ;
    endcase
  end
endmodule

// ----- rtl/ibpm_datapath.sv -----
// Datapath for the IQ block power meter: accumulators, serial divider and root, output register.
// Depends on ibpm_pkg.
`timescale 1ns / 1ps
module ibpm_datapath import ibpm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ibpm_cmd_t               cmd,
  output ibpm_sts_t               sts,
  input  logic signed [SampleW-1:0] in_sample_i,
  input  logic signed [SampleW-1:0] in_sample_q,
  input  logic                    in_last_sample,
  input  logic [15:0]             thr,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic                    out_signal_present,
  output logic [15:0]             out_rms_level,
  output logic [31:0]             out_peak_power,
  output logic [22:0]             out_rc_metric,
  output logic [21:0]             out_lf_metric,
  output logic [14:0]             out_inr_metric,
  output logic [20:0]             out_rde_metric,
  output logic [12:0]             out_block_length
);
  // stage 1: squares registered
  logic [16:0] mi, mq;
  logic [31:0] sq_i_r, sq_q_r;
  logic        sq_v_r, sq_last_r;
  logic [PowW:0] pw;
  logic [SumW-1:0] sum_r;
  logic [PowW-1:0] peak_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic        blk_closes;
  logic        mean_go_r;
  logic        done_r;

  assign mi = in_sample_i[SampleW-1] ? 17'(-$signed({in_sample_i[SampleW-1], in_sample_i}))
                                     : {1'b0, in_sample_i};
  assign mq = in_sample_q[SampleW-1] ? 17'(-$signed({in_sample_q[SampleW-1], in_sample_q}))
                                     : {1'b0, in_sample_q};
  assign cnt_nxt = cnt_r + 1'b1;
  assign blk_closes = in_last_sample || (cnt_nxt == CntW'(MaxBlock));
  assign sts = '{closes: blk_closes, unit_done: done_r};

  always_ff @(posedge clk) begin
    sq_i_r <= 32'(mi * mi);
    sq_q_r <= 32'(mq * mq);
    sq_last_r <= cmd.acc && blk_closes;
  end

  assign pw = {1'b0, sq_i_r} + {1'b0, sq_q_r};

  // squares land in the next cycle; the closing sample's power lands in the first ST_ROOT cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
      sum_r  <= '0;
      peak_r <= '0;
      cnt_r  <= '0;
    end else begin
      sq_v_r <= cmd.acc;
      if (sq_v_r) begin
        sum_r <= sum_r + SumW'(pw);
        if (pw[PowW-1:0] > peak_r) peak_r <= pw[PowW-1:0];
      end
      if (cmd.acc) cnt_r <= blk_closes ? cnt_r : cnt_nxt;
      if (cmd.load_out) begin
        sum_r <= '0;
        peak_r <= '0;
        cnt_r <= '0;
      end
    end
  end

  // block count includes the closing sample
  logic [CntW-1:0] n_r;
  always_ff @(posedge clk) if (sq_last_r) n_r <= cnt_r + 1'b1;

  // register the mean start so it waits until the closing sum and count settle
  always_ff @(posedge clk) begin
    if (!rst_n) mean_go_r <= 1'b0;
    else mean_go_r <= cmd.start_mean;
  end

  // shared iterative unit: restoring division; the mean job then takes square roots of mean and peak
  ibpm_unit_t u_r;
  logic [DivW-1:0] num_r, rem_r;
  logic [DivW-1:0] den_r;
  logic [DivW-1:0] quo_r;
  logic [6:0] it_r;
  ibpm_job_t job_r;
  logic [DivW:0] trial;
  logic [15:0] rms_r, rpk_r;
  logic [31:0] sq_val_r;
  logic [15:0] sq_res_r;
  logic [4:0]  sq_it_r;
  logic [32:0] sq_rem_r;
  logic [32:0] sq_trial;
  logic [31:0] inr_r, rde_r;

  assign trial = {rem_r, num_r[DivW-1]} - {1'b0, den_r};
  assign sq_trial = {sq_rem_r[30:0], sq_val_r[31:30]} - {15'd0, sq_res_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_r <= U_IDLE;
      done_r <= 1'b0;
      job_r <= JOB_MEAN;
    end else begin
      done_r <= 1'b0;
      unique case (u_r)
        U_IDLE: begin
          if (mean_go_r) begin
            num_r <= DivW'(sum_r); den_r <= DivW'(n_r); job_r <= JOB_MEAN;
            rem_r <= '0; quo_r <= '0; it_r <= 7'(DivW); u_r <= U_DIV;
          end else if (cmd.start_inr) begin
            num_r <= DivW'(rms_r) * DivW'(25600); den_r <= DivW'(rpk_r);
            job_r <= JOB_INR; rem_r <= '0; quo_r <= '0; it_r <= 7'(DivW); u_r <= U_DIV;
          end else if (cmd.start_rde) begin
            num_r <= DivW'(peak_r) * DivW'(n_r) * DivW'(256); den_r <= DivW'(sum_r);
            job_r <= JOB_RDE; rem_r <= '0; quo_r <= '0; it_r <= 7'(DivW); u_r <= U_DIV;
          end
        end
        U_DIV: begin
          if (!trial[DivW]) begin
            rem_r <= trial[DivW-1:0];
            quo_r <= {quo_r[DivW-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[DivW-2:0], num_r[DivW-1]};
            quo_r <= {quo_r[DivW-2:0], 1'b0};
          end
          num_r <= {num_r[DivW-2:0], 1'b0};
          it_r <= it_r - 1'b1;
          if (it_r == 7'd1) begin
            u_r <= U_SQRT;
            sq_it_r <= 5'd16; sq_res_r <= '0; sq_rem_r <= '0;
            if (job_r == JOB_MEAN) begin
              sq_val_r <= !trial[DivW] ? 32'({quo_r[DivW-2:0], 1'b1}) :
                                          32'({quo_r[DivW-2:0], 1'b0});
            end else begin
              u_r <= U_IDLE; done_r <= 1'b1;
              if (job_r == JOB_INR)
                inr_r <= (den_r == '0) ? '0 : (!trial[DivW] ? 32'({quo_r[DivW-2:0], 1'b1})
                                                            : 32'({quo_r[DivW-2:0], 1'b0}));
              else
                rde_r <= (den_r == '0) ? '0 : (!trial[DivW] ? 32'({quo_r[DivW-2:0], 1'b1})
                                                            : 32'({quo_r[DivW-2:0], 1'b0}));
            end
          end
        end
        U_SQRT: begin
          sq_val_r <= {sq_val_r[29:0], 2'b00};
          if (!sq_trial[32]) begin
            sq_rem_r <= sq_trial; sq_res_r <= {sq_res_r[14:0], 1'b1};
          end else begin
            sq_rem_r <= {sq_rem_r[30:0], sq_val_r[31:30]}; sq_res_r <= {sq_res_r[14:0], 1'b0};
          end
          sq_it_r <= sq_it_r - 1'b1;
          if (sq_it_r == 5'd1) begin
            if (job_r == JOB_MEAN) begin
              rms_r <= !sq_trial[32] ? {sq_res_r[14:0], 1'b1} : {sq_res_r[14:0], 1'b0};
              job_r <= JOB_PEAK;
              sq_it_r <= 5'd16; sq_res_r <= '0; sq_rem_r <= '0; sq_val_r <= peak_r;
            end else begin
              rpk_r <= !sq_trial[32] ? {sq_res_r[14:0], 1'b1} : {sq_res_r[14:0], 1'b0};
              u_r <= U_IDLE; done_r <= 1'b1;
            end
          end
        end
        default: u_r <= U_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (cmd.load_out) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_signal_present <= rms_r > thr;
      out_rms_level      <= rms_r;
      out_peak_power     <= peak_r;
      out_rc_metric      <= 23'(rms_r * 7'd100);
      out_lf_metric      <= 22'(rms_r * 6'd50);
      out_inr_metric     <= inr_r[14:0];
      out_rde_metric     <= rde_r[20:0];
      out_block_length   <= n_r;
    end
  end
endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for iq_block_power_meter_unit: random and directed IQ sample blocks,
// results predicted in-bench and compared as whole result structs. Depends on ibpm_pkg and the RTL.
`timescale 1ns / 1ps
module testbench import ibpm_pkg::*; ();

  typedef struct packed {
    logic        present;
    logic [15:0] rms;
    logic [31:0] peak;
    logic [22:0] rc;
    logic [21:0] lf;
    logic [14:0] inr;
    logic [20:0] rde;
    logic [12:0] len;
  } meter_res_t;

  typedef struct {
    logic [15:0] si;
    logic [15:0] sq;
    logic        last;
    logic        has_exp;
    meter_res_t  exp_res;
  } stim_row_t;

  logic clk, rst_n;
  logic in_valid, in_ready, in_last_sample;
  logic signed [SampleW-1:0] in_sample_i, in_sample_q;
  logic out_valid, out_ready;
  logic        got_present;
  logic [15:0] got_rms;
  logic [31:0] got_peak;
  logic [22:0] got_rc;
  logic [21:0] got_lf;
  logic [14:0] got_inr;
  logic [20:0] got_rde;
  logic [12:0] got_len;
  meter_res_t got;
  logic cfg_we;
  logic [15:0] cfg_wdata;

  logic [15:0] thresh_m;
  logic [43:0] sum_m;
  logic [31:0] peak_m;
  logic [12:0] count_m;
  meter_res_t pending_results[$];
  meter_res_t typed_results[$];
  int errors = 0;
  int cycles = 0;
  bit hold_off = 0;
  bit idle_free = 0;
  stim_row_t rows[$];

  iq_block_power_meter_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sample_i(in_sample_i), .in_sample_q(in_sample_q), .in_last_sample(in_last_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_signal_present(got_present), .out_rms_level(got_rms), .out_peak_power(got_peak),
    .out_rc_metric(got_rc), .out_lf_metric(got_lf), .out_inr_metric(got_inr),
    .out_rde_metric(got_rde), .out_block_length(got_len),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  assign got = {got_present, got_rms, got_peak, got_rc, got_lf, got_inr, got_rde, got_len};

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] int_root(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] mag_sq(logic [15:0] raw);
    logic [16:0] m;
    m = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    return m * m;
  endfunction

  // Accumulate one sample; returns 1 and the block result when the block closes.
  function automatic bit meter_predict(logic [15:0] si, logic [15:0] sq, logic last,
                                       output meter_res_t r);
    logic [63:0] p, n, rms, rp, inr, rde;
    p = mag_sq(si) + mag_sq(sq);
    sum_m += p[43:0];
    if (p > peak_m) peak_m = p[31:0];
    count_m += 13'd1;
    r = '0;
    if (!last && count_m < MaxBlock) return 0;
    n = count_m;
    rms = int_root({20'd0, sum_m} / n);
    rp = int_root({32'd0, peak_m});
    inr = (rp != 0) ? (rms * 25600) / rp : 0;
    rde = (sum_m != 0) ? ({32'd0, peak_m} * 256 * n) / sum_m : 0;
    r.present = rms > thresh_m;
    r.rms = rms[15:0];
    r.peak = peak_m;
    r.rc = 23'(rms * 100);
    r.lf = 22'(rms * 50);
    r.inr = inr[14:0];
    r.rde = rde[20:0];
    r.len = n[12:0];
    sum_m = 0;
    peak_m = 0;
    count_m = 0;
    return 1;
  endfunction

  task automatic add_row(logic [15:0] si, logic [15:0] sq, logic last,
                         bit typed = 0, meter_res_t e = '0);
    stim_row_t s;
    s.si = si; s.sq = sq; s.last = last; s.has_exp = typed; s.exp_res = e;
    rows.push_back(s);
  endtask

  task automatic send_item(logic [15:0] si, logic [15:0] sq, logic last);
    meter_res_t r;
    while (!idle_free && $urandom_range(99) < 24) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_sample_i <= si;
    in_sample_q <= sq;
    in_last_sample <= last;
    do @(posedge clk); while (!in_ready);
    if (meter_predict(si, sq, last, r)) pending_results.push_back(r);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_thresh(logic [15:0] v);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    thresh_m = v;
  endtask

  task automatic random_blocks(int items, int maxlen);
    int len, k;
    logic [15:0] si, sq;
    k = 0;
    while (k < items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(maxlen) + 1 : $urandom_range(12) + 1;
      for (int j = 0; j < len; j++) begin
        case ($urandom_range(3))
          0: begin si = 16'($urandom); sq = 16'($urandom); end
          1: begin
            si = 16'($urandom_range(2000) - 1000);
            sq = 16'($urandom_range(2000) - 1000);
          end
          2: begin si = 16'h8000; sq = $urandom_range(1) ? 16'h8000 : 16'h7FFF; end
          default: begin si = 16'($urandom_range(7)); sq = 0; end
        endcase
        send_item(si, sq, (j == len - 1) || ($urandom_range(40) == 0));
        k++;
      end
    end
  endtask

  always @(posedge clk) begin
    meter_res_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, actual %p", $time, got);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (got !== e) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, got);
          errors++;
        end
        if (typed_results.size() != 0 && got.len == typed_results[0].len) begin
          e = typed_results.pop_front();
          if (got !== e) begin
            $display("%0t: table mismatch expected %p actual %p", $time, e, got);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      out_ready <= !hold_off && (idle_free || $urandom_range(99) >= 24);
    end
  end

  initial begin
    while (cycles < 2000000) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin
    meter_res_t z, e;
    in_valid = 0; in_sample_i = 0; in_sample_q = 0; in_last_sample = 0;
    cfg_we = 0; cfg_wdata = 0;
    thresh_m = 328; sum_m = 0; peak_m = 0; count_m = 0;
    rst_n = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    z = '0;
    z.len = 1;
    add_row(16'h0000, 16'h0000, 1, 1, z);
    e = '0;
    e.present = 1; e.rms = 32768; e.peak = 32'h4000_0000; e.rc = 3276800;
    e.lf = 1638400; e.inr = 25600; e.rde = 256; e.len = 1;
    add_row(16'h8000, 16'h0000, 1, 1, e);
    e.rms = 46340; e.peak = 32'h8000_0000; e.rc = 4634000; e.lf = 2317000;
    e.inr = 25600;
    add_row(16'h8000, 16'h8000, 1, 1, e);
    add_row(16'h7FFF, 16'h7FFF, 1);
    add_row(16'h7FFF, 16'h8000, 1);
    add_row(16'h0000, 16'h0000, 0);
    add_row(16'h0000, 16'h0000, 0);
    add_row(16'h0001, 16'hFFFF, 1);
    add_row(16'h0000, 16'h0000, 0);
    add_row(16'h8000, 16'h0000, 0);
    add_row(16'h0000, 16'h0000, 0);
    add_row(16'h0001, 16'h0000, 1);
    add_row(16'h0148, 16'h0000, 1);
    add_row(16'h0149, 16'h0000, 1);
    add_row(16'h5555, 16'hAAAA, 0);
    add_row(16'hAAAA, 16'h5555, 1);
    foreach (rows[k]) begin
      if (rows[k].has_exp) typed_results.push_back(rows[k].exp_res);
      send_item(rows[k].si, rows[k].sq, rows[k].last);
      if (rows[k].has_exp) drain();
    end
    drain();

    write_thresh(16'h0000);
    random_blocks(180, 40);
    drain();
    write_thresh(16'hFFFF);
    random_blocks(120, 40);
    drain();

    hold_off = 1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      random_blocks(60, 6);
    join
    drain();

    write_thresh(16'($urandom_range(1000)));
    idle_free = 1;
    random_blocks(100, 30);
    idle_free = 0;
    random_blocks(90, 30);
    drain();

    if (errors == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
